### sv/ogr_pkg.sv
// Shared types and constants of the occupancy grid ray update block.
package ogr_pkg;

  localparam int COORD_W     = 8;   // cell coordinate width on the ports
  localparam int STEP_W      = 16;  // occ_step / free_step width
  localparam int LIMIT_W     = 15;  // logodds_limit width
  localparam int OUT_LO_W    = 16;  // cell_logodds port width
  localparam int TOUCH_W     = 9;   // cells_touched width
  localparam int CLASS_W     = 2;   // occupancy_class width
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int ERR_W       = 11;  // Bresenham decision value, signed
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // request types
  localparam logic REQ_RAY  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // occupancy classes
  localparam logic [CLASS_W-1:0] CLS_UNKNOWN  = 2'd0;
  localparam logic [CLASS_W-1:0] CLS_FREE     = 2'd1;
  localparam logic [CLASS_W-1:0] CLS_OCCUPIED = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OCC_STEP      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FREE_STEP     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOGODDS_LIMIT = 2'd2;

  // configuration reset values
  localparam logic signed [STEP_W-1:0] OCC_STEP_RST  = 16'sd3470;
  localparam logic signed [STEP_W-1:0] FREE_STEP_RST = -16'sd3470;
  localparam logic [LIMIT_W-1:0]       LIMIT_RST     = 15'd32767;

  // classified request, as it travels from the front through the queue
  typedef struct packed {
    logic               is_read;
    logic               xmajor;   // x is the major axis
    logic               x_neg;    // x steps downward
    logic               y_neg;    // y steps downward
    logic [COORD_W-1:0] x0;       // ray start or read cell row
    logic [COORD_W-1:0] y0;       // ray start or read cell column
    logic [COORD_W-1:0] major;    // major axis distance
    logic [COORD_W-1:0] minor;    // minor axis distance
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### sv/occupancy_grid_ray_update.sv
// Top level of the log-odds occupancy grid with Bresenham ray updates.
// The grid holds GRID_DIM x GRID_DIM signed log-odds cells of LOGODDS_BITS bits
// (Q4.12 at 16 bits) in one on-chip memory. A ray beat walks the Bresenham line
// from start to end (a tie in |dx| and |dy| takes y as the major axis), adds
// free_step to every in-grid cell but the last and occ_step to the end cell, each
// sum clamped to +-min(logodds_limit, largest stored value), and returns the count
// of cells touched. A read beat returns one cell's log-odds and class. Exactly one
// result beat comes back per request, in order. The memory does one
// read-modify-write per cell, with the read issued in the cycle before the write,
// and a ray walks N = max(|dx|,|dy|)+1 cells; the sequencer finishes one request
// before it takes the next. A two-entry command queue in front and a result
// register behind let requests and results move while the sequencer works. After
// reset a clearing pass writes zero to all 2^(2*ceil(log2(GRID_DIM))) memory
// words (65536 at the default size), one per cycle; in_stall stays high until it
// finishes. Configuration writes are taken at any time but must only be made
// while the block is idle.
module occupancy_grid_ray_update #(
  parameter int GRID_DIM     = 256,
  parameter int LOGODDS_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // request channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_req_type,
  input  logic [ogr_pkg::COORD_W-1:0]           in_start_x,
  input  logic [ogr_pkg::COORD_W-1:0]           in_start_y,
  input  logic [ogr_pkg::COORD_W-1:0]           in_end_x,
  input  logic [ogr_pkg::COORD_W-1:0]           in_end_y,
  input  logic [ogr_pkg::COORD_W-1:0]           in_read_x,
  input  logic [ogr_pkg::COORD_W-1:0]           in_read_y,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [ogr_pkg::CLASS_W-1:0]           out_occupancy_class,
  output logic signed [ogr_pkg::OUT_LO_W-1:0]   out_cell_logodds,
  output logic [ogr_pkg::TOUCH_W-1:0]           out_cells_touched,
  // configuration write port
  input  logic                                  cfg_we,
  input  logic [ogr_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ogr_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

  logic signed [ogr_pkg::STEP_W-1:0] occ_step_r;
  logic signed [ogr_pkg::STEP_W-1:0] free_step_r;
  logic [ogr_pkg::LIMIT_W-1:0]       limit_r;

  ogr_pkg::q_stat_t q_stat;
  ogr_pkg::cmd_t    push_cmd;
  ogr_pkg::cmd_t    pop_cmd;
  logic             push;
  logic             pop;
  logic             clearing;

  // Configuration registers; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_step_r  <= ogr_pkg::OCC_STEP_RST;
      free_step_r <= ogr_pkg::FREE_STEP_RST;
      limit_r     <= ogr_pkg::LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ogr_pkg::CFG_OCC_STEP:      occ_step_r  <= $signed(cfg_wdata);
        ogr_pkg::CFG_FREE_STEP:     free_step_r <= $signed(cfg_wdata);
        ogr_pkg::CFG_LOGODDS_LIMIT: limit_r     <= cfg_wdata[ogr_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Front end: classify each request beat into a command.
  ogr_front u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .in_start_x  (in_start_x),
    .in_start_y  (in_start_y),
    .in_end_x    (in_end_x),
    .in_end_y    (in_end_y),
    .in_read_x   (in_read_x),
    .in_read_y   (in_read_y),
    .q_stat      (q_stat),
    .clearing    (clearing),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  // Hold commands until the sequencer is free.
  ogr_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .q_stat   (q_stat)
  );

  // Back end: walk rays, update cells, answer reads.
  ogr_back #(
    .GRID_DIM     (GRID_DIM),
    .LOGODDS_BITS (LOGODDS_BITS)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_stat              (q_stat),
    .pop                 (pop),
    .pop_cmd             (pop_cmd),
    .occ_step            (occ_step_r),
    .free_step           (free_step_r),
    .logodds_limit       (limit_r),
    .clearing            (clearing),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_occupancy_class (out_occupancy_class),
    .out_cell_logodds    (out_cell_logodds),
    .out_cells_touched   (out_cells_touched)
  );

  // A ray result never carries a cell value or class.
  ast_ray_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_cells_touched != '0)) |->
      ((out_occupancy_class == ogr_pkg::CLS_UNKNOWN) && (out_cell_logodds == '0)))
    else $error("ray result carries cell data");

  // When the stored value fits the port, the class agrees with its sign.
  ast_class_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (LOGODDS_BITS <= ogr_pkg::OUT_LO_W)) |->
      (((out_occupancy_class == ogr_pkg::CLS_OCCUPIED) == (out_cell_logodds > 0)) &&
       ((out_occupancy_class == ogr_pkg::CLS_FREE) == (out_cell_logodds < 0))))
    else $error("occupancy class disagrees with log-odds sign");

  // Queue status is never both full and empty.
  ast_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("command queue status inconsistent");

  // Nothing is taken from the queue while the grid is being cleared.
  ast_no_pop_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !pop)
    else $error("command popped during clearing pass");

endmodule

### sv/ogr_front.sv
// Front end: takes request beats and classifies them into queue commands.
module ogr_front (
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_req_type,
  input  logic [ogr_pkg::COORD_W-1:0]   in_start_x,
  input  logic [ogr_pkg::COORD_W-1:0]   in_start_y,
  input  logic [ogr_pkg::COORD_W-1:0]   in_end_x,
  input  logic [ogr_pkg::COORD_W-1:0]   in_end_y,
  input  logic [ogr_pkg::COORD_W-1:0]   in_read_x,
  input  logic [ogr_pkg::COORD_W-1:0]   in_read_y,
  input  ogr_pkg::q_stat_t              q_stat,
  input  logic                          clearing,
  output logic                          push,
  output ogr_pkg::cmd_t                 push_cmd
);

  logic [ogr_pkg::COORD_W-1:0] adx;
  logic [ogr_pkg::COORD_W-1:0] ady;
  logic                        xmajor;

  assign in_stall = q_stat.full || clearing;
  assign push     = in_valid && !in_stall;

  always_comb begin
    adx    = (in_end_x >= in_start_x) ? (in_end_x - in_start_x) : (in_start_x - in_end_x);
    ady    = (in_end_y >= in_start_y) ? (in_end_y - in_start_y) : (in_start_y - in_end_y);
    // a tie makes y the major axis
    xmajor = adx > ady;

    push_cmd = '0;
    if (in_req_type == ogr_pkg::REQ_READ) begin
      push_cmd.is_read = 1'b1;
      push_cmd.x0      = in_read_x;
      push_cmd.y0      = in_read_y;
    end else begin
      push_cmd.is_read = 1'b0;
      push_cmd.xmajor  = xmajor;
      push_cmd.x_neg   = !(in_end_x > in_start_x);
      push_cmd.y_neg   = !(in_end_y > in_start_y);
      push_cmd.x0      = in_start_x;
      push_cmd.y0      = in_start_y;
      push_cmd.major   = xmajor ? adx : ady;
      push_cmd.minor   = xmajor ? ady : adx;
    end
  end

endmodule

### sv/ogr_fifo.sv
// Short command queue between the front end and the grid sequencer.
module ogr_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ogr_pkg::cmd_t     push_cmd,
  input  logic              pop,
  output ogr_pkg::cmd_t     pop_cmd,
  output ogr_pkg::q_stat_t  q_stat
);

  ogr_pkg::cmd_t                   ent_r [ogr_pkg::QUEUE_DEPTH];
  logic [ogr_pkg::QPTR_W-1:0]      wr_ptr_r;
  logic [ogr_pkg::QPTR_W-1:0]      rd_ptr_r;
  logic [ogr_pkg::QCNT_W-1:0]      count_r;

  assign q_stat.full  = count_r == ogr_pkg::QCNT_W'(ogr_pkg::QUEUE_DEPTH);
  assign q_stat.empty = count_r == '0;
  assign pop_cmd      = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == ogr_pkg::QPTR_W'(ogr_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == ogr_pkg::QPTR_W'(ogr_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

### sv/ogr_back.sv
// Grid sequencer: cell memory, clearing pass, line walk, saturating update, result register.
module ogr_back #(
  parameter int GRID_DIM     = 256,
  parameter int LOGODDS_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  ogr_pkg::q_stat_t                      q_stat,
  output logic                                  pop,
  input  ogr_pkg::cmd_t                         pop_cmd,
  input  logic signed [ogr_pkg::STEP_W-1:0]     occ_step,
  input  logic signed [ogr_pkg::STEP_W-1:0]     free_step,
  input  logic [ogr_pkg::LIMIT_W-1:0]           logodds_limit,
  output logic                                  clearing,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [ogr_pkg::CLASS_W-1:0]           out_occupancy_class,
  output logic signed [ogr_pkg::OUT_LO_W-1:0]   out_cell_logodds,
  output logic [ogr_pkg::TOUCH_W-1:0]           out_cells_touched
);

  localparam int AXB   = $clog2(GRID_DIM);
  localparam int CW    = (AXB > ogr_pkg::COORD_W) ? AXB : ogr_pkg::COORD_W;
  localparam int AW    = 2 * AXB;
  localparam int DEPTH = 1 << AW;
  localparam int LB    = LOGODDS_BITS;
  localparam int SW    = ((LB > ogr_pkg::STEP_W) ? LB : ogr_pkg::STEP_W) + 1;
  localparam logic signed [SW-1:0] CAP = SW'((64'd1 << (LB - 1)) - 64'd1);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_WALK   = 6'b000100,
    S_DRAIN  = 6'b001000,
    S_READ   = 6'b010000,
    S_RESULT = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // cell memory
  logic [LB-1:0]        mem [DEPTH];
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic signed [LB-1:0] rd_data_r;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [LB-1:0]        wr_data;

  logic [AW-1:0]        clr_addr_r;

  // walker
  ogr_pkg::cmd_t                    cmd_r;
  logic [ogr_pkg::COORD_W-1:0]      cur_x_r;
  logic [ogr_pkg::COORD_W-1:0]      cur_y_r;
  logic [ogr_pkg::COORD_W-1:0]      step_i_r;
  logic signed [ogr_pkg::ERR_W-1:0] err_r;
  logic signed [ogr_pkg::ERR_W-1:0] err_init;
  logic signed [ogr_pkg::ERR_W-1:0] two_min;
  logic signed [ogr_pkg::ERR_W-1:0] two_maj;
  logic                             err_ge;
  logic                             walk_last;
  logic                             move_x;
  logic                             move_y;

  // update stage
  logic                             p_valid_r;
  logic                             p_last_r;
  logic [AW-1:0]                    p_addr_r;
  logic signed [SW-1:0]             eff_lim_r;
  logic signed [SW-1:0]             lim_w;
  logic signed [SW-1:0]             sum;
  logic signed [SW-1:0]             sat;
  logic signed [ogr_pkg::STEP_W-1:0] step_sel;
  logic [ogr_pkg::TOUCH_W-1:0]      touched_r;
  logic                             rd_grid_r;
  logic signed [LB-1:0]             rd_val;

  logic                             out_load;
  logic                             out_valid_r;
  logic [ogr_pkg::CLASS_W-1:0]      out_class_r;
  logic signed [ogr_pkg::OUT_LO_W-1:0] out_lo_r;
  logic [ogr_pkg::TOUCH_W-1:0]      out_touched_r;

  function automatic logic in_grid(input logic [ogr_pkg::COORD_W-1:0] x,
                                   input logic [ogr_pkg::COORD_W-1:0] y);
    return (int'(x) < GRID_DIM) && (int'(y) < GRID_DIM);
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [ogr_pkg::COORD_W-1:0] x,
                                              input logic [ogr_pkg::COORD_W-1:0] y);
    logic [CW-1:0] xe;
    logic [CW-1:0] ye;
    xe = CW'(x);
    ye = CW'(y);
    return {xe[AXB-1:0], ye[AXB-1:0]};
  endfunction

  assign clearing  = state_r == S_CLEAR;
  assign pop       = (state_r == S_IDLE) && !q_stat.empty;
  assign out_load  = (state_r == S_RESULT) && (!out_valid_r || !out_stall);

  assign err_ge    = !err_r[ogr_pkg::ERR_W-1];
  assign walk_last = step_i_r == cmd_r.major;
  assign two_min   = $signed(ogr_pkg::ERR_W'({cmd_r.minor, 1'b0}));
  assign two_maj   = $signed(ogr_pkg::ERR_W'({cmd_r.major, 1'b0}));
  assign err_init  = $signed(ogr_pkg::ERR_W'({pop_cmd.minor, 1'b0}))
                   - $signed(ogr_pkg::ERR_W'(pop_cmd.major));
  assign move_x    = cmd_r.xmajor || err_ge;
  assign move_y    = !cmd_r.xmajor || err_ge;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:  if (clr_addr_r == '1) state_nxt = S_IDLE;
      S_IDLE:   if (pop) state_nxt = pop_cmd.is_read ? S_READ : S_WALK;
      S_WALK:   if (walk_last) state_nxt = S_DRAIN;
      S_DRAIN:  state_nxt = S_RESULT;
      S_READ:   state_nxt = S_RESULT;
      S_RESULT: if (out_load) state_nxt = S_IDLE;
      default:  state_nxt = S_CLEAR;
    endcase
  end

  // memory ports
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cell_addr(cur_x_r, cur_y_r);
    if (state_r == S_WALK) begin
      rd_en = 1'b1;
    end else if (state_r == S_READ) begin
      rd_en   = 1'b1;
      rd_addr = cell_addr(cmd_r.x0, cmd_r.y0);
    end
  end

  always_comb begin
    lim_w    = $signed(SW'(logodds_limit));
    step_sel = p_last_r ? occ_step : free_step;
    sum      = SW'(rd_data_r) + SW'(step_sel);
    if (sum > eff_lim_r) begin
      sat = eff_lim_r;
    end else if (sum < -eff_lim_r) begin
      sat = -eff_lim_r;
    end else begin
      sat = sum;
    end
    wr_en   = clearing || p_valid_r;
    wr_addr = clearing ? clr_addr_r : p_addr_r;
    wr_data = clearing ? '0 : LB'(sat);
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_addr_r <= '0;
      p_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clearing) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      p_valid_r <= (state_r == S_WALK) && in_grid(cur_x_r, cur_y_r);
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // walker and update datapath
  always_ff @(posedge clk) begin
    eff_lim_r <= (lim_w < CAP) ? lim_w : CAP;
    p_last_r  <= walk_last;
    p_addr_r  <= rd_addr;
    if (p_valid_r) begin
      touched_r <= touched_r + 1'b1;
    end
    if (pop) begin
      cmd_r     <= pop_cmd;
      cur_x_r   <= pop_cmd.x0;
      cur_y_r   <= pop_cmd.y0;
      step_i_r  <= '0;
      err_r     <= err_init;
      touched_r <= '0;
    end else if (state_r == S_WALK) begin
      // emit the cell, then advance major and, on a nonnegative decision, minor
      step_i_r <= step_i_r + 1'b1;
      if (move_x) begin
        cur_x_r <= cmd_r.x_neg ? cur_x_r - 1'b1 : cur_x_r + 1'b1;
      end
      if (move_y) begin
        cur_y_r <= cmd_r.y_neg ? cur_y_r - 1'b1 : cur_y_r + 1'b1;
      end
      err_r <= err_r + (err_ge ? (two_min - two_maj) : two_min);
    end
    if (state_r == S_READ) begin
      rd_grid_r <= in_grid(cmd_r.x0, cmd_r.y0);
    end
  end

  // result register
  assign rd_val = rd_grid_r ? rd_data_r : '0;

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (cmd_r.is_read) begin
        out_lo_r      <= ogr_pkg::OUT_LO_W'(rd_val);
        out_touched_r <= '0;
        if (rd_val > 0) begin
          out_class_r <= ogr_pkg::CLS_OCCUPIED;
        end else if (rd_val < 0) begin
          out_class_r <= ogr_pkg::CLS_FREE;
        end else begin
          out_class_r <= ogr_pkg::CLS_UNKNOWN;
        end
      end else begin
        out_lo_r      <= '0;
        out_class_r   <= ogr_pkg::CLS_UNKNOWN;
        out_touched_r <= touched_r;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_occupancy_class = out_class_r;
  assign out_cell_logodds    = out_lo_r;
  assign out_cells_touched   = out_touched_r;

endmodule
